FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the sort engine (spbs_back)
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SPBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SPBS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SPBS_ASSERT(lbl, clk, rstn, prop, msg)
`define SPBS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: hw/rtl/spbs_pkg.sv
// ---------------------------------------------------------------------------
// spbs_pkg
// shared constants, types and helpers of the stable priority sort core
// ---------------------------------------------------------------------------
package spbs_pkg;

  localparam int MAX_JOBS        = 64;
  localparam int PRIORITY_LEVELS = 10;
  localparam int IDX_W           = 12;
  localparam int PRIO_W          = 4;
  localparam int LVL_W           = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int JOB_AW          = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W           = $clog2(MAX_JOBS + 1);
  localparam int QUEUE_DEPTH     = 4;

  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [LVL_W-1:0]           lvl_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [JOB_AW-1:0]          jaddr_t;
  typedef logic [PRIORITY_LEVELS-1:0] lvl_mask_t;

  typedef struct packed {
    idx_t idx;
    lvl_t prio;
    logic last;
    logic drop;
  } item_t;

  typedef struct packed {
    lvl_t prio;
    idx_t idx;
  } entry_t;

  typedef struct packed {
    logic found;
    lvl_t lvl;
  } lvl_sel_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH
  } back_state_e;

  // lowest set level in mask, at or above (incl) / strictly above from
  function automatic lvl_sel_t lowest_level(lvl_mask_t m, lvl_t from, logic incl);
    lvl_sel_t r;
    r.found = 1'b0;
    r.lvl   = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (m[i] && ((LVL_W'(i) > from) || (incl && (LVL_W'(i) == from)))) begin
        r.found = 1'b1;
        r.lvl   = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/spbs_front.sv
// ---------------------------------------------------------------------------
// spbs_front
// input stage: clamps priority and marks entries beyond store capacity
// ---------------------------------------------------------------------------
module spbs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [spbs_pkg::IDX_W-1:0]  job_index_i,
  input  logic [spbs_pkg::PRIO_W-1:0] priority_level_i,
  input  logic                        last_entry_i,
  output logic                        push_o,
  output spbs_pkg::item_t             item_o,
  input  logic                        full_i
);
  import spbs_pkg::*;

  cnt_t count_q, count_d;
  logic accept;
  logic drop;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign drop       = (count_q == CNT_W'(MAX_JOBS));
  assign push_o     = accept;

  always_comb begin
    item_o.idx  = job_index_i;
    item_o.last = last_entry_i;
    item_o.drop = drop;
    if (priority_level_i > PRIO_W'(PRIORITY_LEVELS - 1)) begin
      item_o.prio = LVL_W'(PRIORITY_LEVELS - 1);
    end else begin
      item_o.prio = priority_level_i[LVL_W-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (last_entry_i) begin
        count_d = '0;
      end else if (!drop) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: hw/rtl/spbs_fifo.sv
// ---------------------------------------------------------------------------
// spbs_fifo
// short queue decoupling the input stage from the sort engine
// ---------------------------------------------------------------------------
module spbs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spbs_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output spbs_pkg::item_t item_o
);
  import spbs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic           do_push, do_pop;

  assign full_o  = (fill_q == FW'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

FILE: hw/rtl/spbs_back.sv
// ---------------------------------------------------------------------------
// spbs_back
// sort engine: stores a list, then scans the store once per occupied level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spbs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  spbs_pkg::item_t            q_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [spbs_pkg::IDX_W-1:0] sorted_index_o,
  output logic                       end_of_run_o
);
  import spbs_pkg::*;

  entry_t      mem [MAX_JOBS];

  back_state_e state_q, state_d;
  cnt_t        cnt_q, cnt_d;
  cnt_t        n_q, n_d;
  cnt_t        rem_q, rem_d;
  lvl_mask_t   mask_q, mask_d;
  lvl_t        level_q, level_d;
  jaddr_t      ptr_q, ptr_d;
  logic        rv_q, rv_d;
  lvl_t        rlevel_q;
  entry_t      rdata_q;
  logic        out_valid_q;
  idx_t        out_idx_q;
  logic        out_eor_q;

  logic        match, out_free, advance, emit, issue, wr_en;
  entry_t      wr_entry;
  lvl_mask_t   mask_new;
  lvl_sel_t    sel;

  assign match    = (rdata_q.prio == rlevel_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = !rv_q || !match || out_free;
  assign emit     = rv_q && match && out_free;
  assign wr_entry = '{prio: q_item_i.prio, idx: q_item_i.idx};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    rem_d    = rem_q;
    mask_d   = mask_q;
    level_d  = level_q;
    ptr_d    = ptr_q;
    q_pop_o  = 1'b0;
    wr_en    = 1'b0;
    issue    = 1'b0;
    mask_new = mask_q;
    sel      = '0;
    if (emit) begin
      rem_d = rem_q - CNT_W'(1);
    end
    case (state_q)
      ST_LOAD: begin
        q_pop_o = 1'b1;
        if (q_valid_i) begin
          if (!q_item_i.drop) begin
            wr_en    = 1'b1;
            cnt_d    = cnt_q + CNT_W'(1);
            mask_new = mask_q | (PRIORITY_LEVELS'(1) << q_item_i.prio);
          end
          mask_d = mask_new;
          if (q_item_i.last) begin
            sel     = lowest_level(mask_new, '0, 1'b1);
            state_d = ST_SCAN;
            n_d     = cnt_d;
            rem_d   = cnt_d;
            cnt_d   = '0;
            level_d = sel.lvl;
            ptr_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        if (advance) begin
          issue = 1'b1;
          if (CNT_W'(ptr_q) == n_q - CNT_W'(1)) begin
            ptr_d = '0;
            sel   = lowest_level(mask_q, level_q, 1'b0);
            if (sel.found) begin
              level_d = sel.lvl;
            end else begin
              state_d = ST_FLUSH;
            end
          end else begin
            ptr_d = ptr_q + JOB_AW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!rv_q) begin
          state_d = ST_LOAD;
          mask_d  = '0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    rv_d = advance ? issue : rv_q;
  end

  // entry store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[JOB_AW-1:0]] <= wr_entry;
    end
    if (issue) begin
      rdata_q  <= mem[ptr_q];
      rlevel_q <= level_q;
    end
    if (emit) begin
      out_idx_q <= rdata_q.idx;
      out_eor_q <= (rem_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      rem_q       <= '0;
      mask_q      <= '0;
      level_q     <= '0;
      ptr_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      rem_q   <= rem_d;
      mask_q  <= mask_d;
      level_q <= level_d;
      ptr_q   <= ptr_d;
      rv_q    <= rv_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_index_o = out_idx_q;
  assign end_of_run_o   = out_eor_q;

  `SPBS_ASSERT_NEVER(a_no_read_in_load, clk_i, rst_ni, rv_q && (state_q == ST_LOAD), "read in flight while loading")
  `SPBS_ASSERT_NEVER(a_emit_over_count, clk_i, rst_ni, emit && (rem_q == '0), "more results than stored entries")
  `SPBS_ASSERT(a_eor_ends_run, clk_i, rst_ni, (emit && (rem_q == CNT_W'(1))) |=> (rem_q == '0), "run count not exhausted at end of run")
  `SPBS_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, cnt_q > CNT_W'(MAX_JOBS), "store fill beyond capacity")

endmodule

FILE: hw/rtl/stable_priority_bucket_sort_core.sv
// ---------------------------------------------------------------------------
// stable_priority_bucket_sort_core
// stable sort of job indices by priority level, 0 first
// ---------------------------------------------------------------------------
// Entries are taken one per cycle while the four-deep queue has room and
// written one per cycle into a 64-entry store while loading; priorities
// above 9 count as 9 and entries past the 64th are dropped, though a dropped
// last entry still closes the list. After the last entry the store is scanned
// through its single read port once for each priority level that occurs in
// the list, one entry per cycle unless the output stalls, one result at most
// per cycle; results of one level keep load order and the final result
// carries end_of_run. Input transactions for the next list are taken while
// the queue has room and loading resumes once the scan is done.
// ---------------------------------------------------------------------------
module stable_priority_bucket_sort_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [spbs_pkg::IDX_W-1:0]  job_index_i,
  input  logic [spbs_pkg::PRIO_W-1:0] priority_level_i,
  input  logic                        last_entry_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [spbs_pkg::IDX_W-1:0]  sorted_index_o,
  output logic                        end_of_run_o
);
  import spbs_pkg::*;

  logic  push, full, q_valid, q_pop;
  item_t push_item, q_item;

  spbs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .job_index_i      (job_index_i),
    .priority_level_i (priority_level_i),
    .last_entry_i     (last_entry_i),
    .push_o           (push),
    .item_o           (push_item),
    .full_i           (full)
  );

  spbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  spbs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_item_i       (q_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_index_o (sorted_index_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule

FILE: tb/stable_priority_bucket_sort_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stable_priority_bucket_sort_core_test
// self-checking bench for the stable priority sort core
// ---------------------------------------------------------------------------
// Job lists are fed through the valid/ready input channel and every sorted
// index is compared with a local model that keeps the lists it has seen and
// orders them by clamped priority, load order kept within a level, or for
// single-entry lists with the table's index. A short table of directed lists
// (field extremes, clamped priorities, repeated levels) is followed by random
// lists, among them lists that fill the store and overflow it. Both channels
// idle in random bursts, and the last part of the run runs without idling.
// ---------------------------------------------------------------------------
module stable_priority_bucket_sort_core_test;
  import spbs_pkg::*;

  typedef struct {
    idx_t idx;
    logic eor;
  } sorted_job_t;

  typedef struct {
    idx_t              idx;
    logic [PRIO_W-1:0] prio;
    logic              last;
    bit                typed;
    idx_t              typed_idx;
  } job_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  idx_t              job_index_i;
  logic [PRIO_W-1:0] priority_level_i;
  logic              last_entry_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  idx_t              sorted_index_o;
  logic              end_of_run_o;

  entry_t      held_jobs[$];
  sorted_job_t sorted_queue[$];
  int          error_count = 0;
  int          items_sent  = 0;
  bit          quiet       = 1'b0;
  int          stall_left  = 0;
  int          calm_left   = 0;

  stable_priority_bucket_sort_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .job_index_i      (job_index_i),
    .priority_level_i (priority_level_i),
    .last_entry_i     (last_entry_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sorted_index_o   (sorted_index_o),
    .end_of_run_o     (end_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic take_entry(idx_t idx, logic [PRIO_W-1:0] prio, logic last, bit predicted);
    entry_t      e;
    sorted_job_t run[$];
    e.idx  = idx;
    e.prio = (prio >= PRIORITY_LEVELS) ? lvl_t'(PRIORITY_LEVELS - 1) : lvl_t'(prio);
    if (held_jobs.size() < MAX_JOBS) held_jobs.push_back(e);
    if (last) begin
      for (int lvl = 0; lvl < PRIORITY_LEVELS; lvl++) begin
        foreach (held_jobs[j]) begin
          if (held_jobs[j].prio == lvl) run.push_back('{held_jobs[j].idx, 1'b0});
        end
      end
      if (run.size() > 0) run[run.size() - 1].eor = 1'b1;
      if (predicted) begin
        foreach (run[k]) sorted_queue.push_back(run[k]);
      end
      held_jobs.delete();
    end
  endtask

  function automatic int pick_gap(bit calm);
    if (quiet || calm) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic push_entry(job_row_t row, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    job_index_i      <= row.idx;
    priority_level_i <= row.prio;
    last_entry_i     <= row.last;
    do @(posedge clk_i); while (!in_ready_o);
    take_entry(row.idx, row.prio, row.last, !row.typed);
    if (row.typed) sorted_queue.push_back('{row.typed_idx, 1'b1});
    items_sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (quiet || calm_left > 0) begin
      out_ready_i <= 1'b1;
      if (calm_left > 0) calm_left <= calm_left - 1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      out_ready_i <= 1'b1;
      calm_left   <= $urandom_range(20, 80);
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sorted_job_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_queue.size() == 0) begin
        $error("unexpected transaction: sorted_index %0d end_of_run %0b",
               sorted_index_o, end_of_run_o);
        error_count++;
      end else begin
        want = sorted_queue.pop_front();
        if (sorted_index_o !== want.idx) begin
          $error("sorted_index: expected %0d, actual %0d", want.idx, sorted_index_o);
          error_count++;
        end
        if (end_of_run_o !== want.eor) begin
          $error("end_of_run: expected %0b, actual %0b", want.eor, end_of_run_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    job_row_t rows[24];
    job_row_t row;
    int       list_no;
    int       len;
    int       pick;
    bit       calm;

    rows = '{
      // single-entry lists, result readable directly
      '{12'h000, 4'd0,  1'b1, 1'b1, 12'h000},
      '{12'hfff, 4'd9,  1'b1, 1'b1, 12'hfff},
      '{12'habc, 4'd15, 1'b1, 1'b1, 12'habc},
      '{12'h555, 4'd10, 1'b1, 1'b1, 12'h555},
      // repeated levels, stability
      '{12'h101, 4'd9,  1'b0, 1'b0, 12'h000},
      '{12'h102, 4'd0,  1'b0, 1'b0, 12'h000},
      '{12'h103, 4'd5,  1'b0, 1'b0, 12'h000},
      '{12'h104, 4'd0,  1'b0, 1'b0, 12'h000},
      '{12'h105, 4'd12, 1'b0, 1'b0, 12'h000},
      '{12'h106, 4'd3,  1'b0, 1'b0, 12'h000},
      '{12'h107, 4'd9,  1'b0, 1'b0, 12'h000},
      '{12'h108, 4'd0,  1'b1, 1'b0, 12'h000},
      // remaining levels and clamped values
      '{12'hfff, 4'd1,  1'b0, 1'b0, 12'h000},
      '{12'h000, 4'd2,  1'b0, 1'b0, 12'h000},
      '{12'h2aa, 4'd4,  1'b0, 1'b0, 12'h000},
      '{12'hd55, 4'd6,  1'b0, 1'b0, 12'h000},
      '{12'h333, 4'd7,  1'b0, 1'b0, 12'h000},
      '{12'hccc, 4'd8,  1'b0, 1'b0, 12'h000},
      '{12'h0f0, 4'd11, 1'b0, 1'b0, 12'h000},
      '{12'hf0f, 4'd13, 1'b0, 1'b0, 12'h000},
      '{12'h777, 4'd14, 1'b0, 1'b0, 12'h000},
      '{12'h888, 4'd1,  1'b0, 1'b0, 12'h000},
      '{12'h999, 4'd9,  1'b0, 1'b0, 12'h000},
      '{12'h123, 4'd10, 1'b1, 1'b0, 12'h000}
    };

    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    job_index_i      = '0;
    priority_level_i = '0;
    last_entry_i     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[r]) push_entry(rows[r], pick_gap(1'b0));

    list_no = 0;
    while (items_sent < 410) begin
      pick = $urandom_range(0, 15);
      if (list_no == 0) len = 66;
      else if (list_no == 1) len = 64;
      else if (pick == 0) len = $urandom_range(65, 70);
      else if (pick == 1) len = $urandom_range(20, 63);
      else len = $urandom_range(1, 12);
      calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++) begin
        row.idx       = idx_t'($urandom_range(0, 4095));
        row.prio      = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(10, 15))
                                                    : PRIO_W'($urandom_range(0, 9));
        row.last      = (k == len - 1);
        row.typed     = 1'b0;
        row.typed_idx = '0;
        if (items_sent >= 350) quiet = 1'b1;
        push_entry(row, pick_gap(calm));
      end
      list_no++;
    end
    in_valid_i <= 1'b0;

    while (sorted_queue.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/spbs_pkg.sv
hw/rtl/spbs_front.sv
hw/rtl/spbs_fifo.sv
hw/rtl/spbs_back.sv
hw/rtl/stable_priority_bucket_sort_core.sv
tb/stable_priority_bucket_sort_core_test.sv
